### design/pbsp_pkg.sv
`timescale 1ns / 1ps

package pbsp_pkg;

  localparam int CoordWidth = 16;
  localparam int NumEdges   = 12;
  localparam int CntW       = 4;
  localparam int MulAW      = 35;
  localparam int MulBW      = 17;
  localparam int MulPW      = MulAW + MulBW;
  localparam int AccW       = 53;
  localparam int NumW       = 35;
  localparam int DenW       = 33;
  localparam int DvdW       = 36;
  localparam int DvsW       = 17;
  localparam int DivCntW    = 6;

  localparam logic signed [15:0] BoxMinReset = -16'sd2048;
  localparam logic signed [15:0] BoxMaxReset = 16'sd2048;

  localparam logic [2:0] RegMinX = 3'd0;
  localparam logic [2:0] RegMinY = 3'd1;
  localparam logic [2:0] RegMinZ = 3'd2;
  localparam logic [2:0] RegMaxX = 3'd3;
  localparam logic [2:0] RegMaxY = 3'd4;
  localparam logic [2:0] RegMaxZ = 3'd5;

  typedef struct packed {
    logic       cx;
    logic       cy;
    logic       cz;
    logic [1:0] axis;
    logic [5:0] mask;
  } edge_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [5:0]         mask;
  } hit_t;

  function automatic edge_t edge_info(input logic [CntW-1:0] e);
    edge_t r;
    case (e)
      4'd0:    r = '{1'b0, 1'b0, 1'b0, 2'd0, 6'h11};
      4'd1:    r = '{1'b0, 1'b1, 1'b0, 2'd0, 6'h21};
      4'd2:    r = '{1'b0, 1'b0, 1'b1, 2'd0, 6'h12};
      4'd3:    r = '{1'b0, 1'b1, 1'b1, 2'd0, 6'h22};
      4'd4:    r = '{1'b0, 1'b0, 1'b0, 2'd1, 6'h05};
      4'd5:    r = '{1'b1, 1'b0, 1'b0, 2'd1, 6'h09};
      4'd6:    r = '{1'b0, 1'b0, 1'b1, 2'd1, 6'h06};
      4'd7:    r = '{1'b1, 1'b0, 1'b1, 2'd1, 6'h0A};
      4'd8:    r = '{1'b0, 1'b0, 1'b0, 2'd2, 6'h14};
      4'd9:    r = '{1'b1, 1'b0, 1'b0, 2'd2, 6'h18};
      4'd10:   r = '{1'b0, 1'b1, 1'b0, 2'd2, 6'h24};
      4'd11:   r = '{1'b1, 1'b1, 1'b0, 2'd2, 6'h28};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/plane_box_section_polygon.sv
`timescale 1ns / 1ps

// Channel | Dir | Transfer            | Payload
// in_     | in  | in_tvalid&in_tready | tdata: px, py, pz, nx, ny, nz (16b each)
// out_    | out | out_tvalid&tready   | tdata: x, y, z, hit_index, face_mask; tuser found; tlast
// cfg_    | in  | cfg_we              | cfg_index selects box bound, cfg_data value
//
// One plane per transfer; in_tready is high only when idle.
// Edge scan: DEN, NUM, CHK and NXT per edge, plus DIV and FIX per hit (serial divider, 1 bit/cycle).
// Ordering: shared multiplier, RJ, RMUL and RCMP per pair of hits, up to 110 pairs.
// Output scan: walks the stored hits for each rank in turn, and waits on output stalls.
// rst_n is synchronous; box bounds reset to -0.5 / +0.5.
module plane_box_section_polygon import pbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // plane_px, plane_py, plane_pz, normal_x, normal_y, normal_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // point_x, point_y, point_z, hit_index, face_mask, zero pad
  output logic        out_tuser,  // found
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_DEN   = 13'b0000000000010,
    ST_NUM   = 13'b0000000000100,
    ST_CHK   = 13'b0000000001000,
    ST_DIV   = 13'b0000000010000,
    ST_FIX   = 13'b0000000100000,
    ST_NXT   = 13'b0000001000000,
    ST_RI    = 13'b0000010000000,
    ST_RJ    = 13'b0000100000000,
    ST_RMUL  = 13'b0001000000000,
    ST_RCMP  = 13'b0010000000000,
    ST_OSCAN = 13'b0100000000000,
    ST_OWAIT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] lo_r [3];
  logic signed [15:0] hi_r [3];
  logic signed [15:0] p_r  [3];
  logic signed [15:0] n_r  [3];

  logic [CntW-1:0] e_r, cnt_r, i_r, j_r, k_r, si_r, r_r, rk_r;
  logic [3:0]      step_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [MulAW-1:0] x_r;
  logic signed [DenW-1:0]  den_r;
  logic [DvdW-1:0]         qd_r;
  logic [DvsW-1:0]         rem_r, dvs_r;
  logic [DivCntW-1:0]      dcnt_r;
  logic                    neg_r;
  logic signed [16:0] o_r [3];
  logic signed [16:0] u_r [3];
  logic signed [16:0] v_r [3];

  hit_t            hit_mem [NumEdges];
  logic [CntW-1:0] rank_r  [NumEdges];

  logic        out_valid_r, out_found_r, out_last_r;
  logic [15:0] out_x_r, out_y_r, out_z_r;
  logic [3:0]  out_idx_r;
  logic [5:0]  out_mask_r;

  // edge geometry
  edge_t              ed;
  logic signed [15:0] s_c [3];
  logic signed [16:0] d_c, diff_c;
  logic signed [15:0] na_c;
  always_comb begin
    ed     = edge_info(e_r);
    s_c[0] = ed.cx ? hi_r[0] : lo_r[0];
    s_c[1] = ed.cy ? hi_r[1] : lo_r[1];
    s_c[2] = ed.cz ? hi_r[2] : lo_r[2];
    d_c    = 17'(hi_r[ed.axis]) - 17'(lo_r[ed.axis]);
    na_c   = n_r[ed.axis];
    diff_c = 17'(p_r[step_r[1:0]]) - 17'(s_c[step_r[1:0]]);
  end

  // shared multiplier
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DEN: begin
        mul_a = MulAW'(d_c);
        mul_b = MulBW'(na_c);
      end
      ST_NUM: begin
        mul_a = MulAW'(diff_c);
        mul_b = MulBW'(n_r[step_r[1:0]]);
      end
      ST_RMUL: begin
        case (step_r)
          4'd0:    begin mul_a = MulAW'(u_r[1]); mul_b = v_r[2]; end
          4'd1:    begin mul_a = MulAW'(u_r[2]); mul_b = v_r[1]; end
          4'd2:    begin mul_a = x_r; mul_b = MulBW'(n_r[0]); end
          4'd3:    begin mul_a = MulAW'(u_r[2]); mul_b = v_r[0]; end
          4'd4:    begin mul_a = MulAW'(u_r[0]); mul_b = v_r[2]; end
          4'd5:    begin mul_a = x_r; mul_b = MulBW'(n_r[1]); end
          4'd6:    begin mul_a = MulAW'(u_r[0]); mul_b = v_r[1]; end
          4'd7:    begin mul_a = MulAW'(u_r[1]); mul_b = v_r[0]; end
          4'd8:    begin mul_a = x_r; mul_b = MulBW'(n_r[2]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MulPW'(mul_a) * MulPW'(mul_b);
  end

  // hit test and divider setup
  logic signed [NumW-1:0] num_c, den_x;
  logic [NumW-1:0]        num_abs;
  logic [15:0]            na_abs;
  logic                   keep_c;
  always_comb begin
    num_c   = acc_r[NumW-1:0];
    den_x   = NumW'(den_r);
    num_abs = num_c[NumW-1] ? NumW'(-num_c) : NumW'(num_c);
    na_abs  = na_c[15] ? 16'(-na_c) : 16'(na_c);
    if (den_r > 0)
      keep_c = (num_c >= 0) && (num_c <= den_x);
    else
      keep_c = (den_r != 0) && (num_c <= 0) && (num_c >= den_x);
  end

  // divider step
  logic [DvsW:0] dsh;
  logic          dbit;
  always_comb begin
    dsh  = {rem_r, qd_r[DvdW-1]};
    dbit = dsh >= {1'b0, dvs_r};
  end

  // hit coordinate
  logic signed [37:0] q_s, sum_c;
  logic signed [15:0] coord_c;
  localparam logic signed [37:0] SatHi = 38'((64'sd1 <<< (CoordWidth - 1)) - 1);
  localparam logic signed [37:0] SatLo = -SatHi - 38'sd1;
  always_comb begin
    q_s   = neg_r ? -38'($signed({2'b00, qd_r})) : 38'($signed({2'b00, qd_r}));
    sum_c = 38'(s_c[ed.axis]) + q_s;
    if (sum_c > SatHi)
      coord_c = 16'(SatHi);
    else if (sum_c < SatLo)
      coord_c = 16'(SatLo);
    else
      coord_c = sum_c[15:0];
  end

  // single memory read port
  logic [CntW-1:0] rd_addr;
  hit_t            rd_hit;
  always_comb begin
    case (state_r)
      ST_RI:   rd_addr = i_r;
      ST_RJ:   rd_addr = j_r;
      default: rd_addr = si_r;
    endcase
    rd_hit = hit_mem[rd_addr];
  end

  logic last_edge, rank_hit, scan_wrap;
  always_comb begin
    last_edge = e_r == CntW'(NumEdges - 1);
    rank_hit  = rank_r[si_r] == r_r;
    scan_wrap = si_r == cnt_r - 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DEN;
      ST_DEN:   state_nxt = ST_NUM;
      ST_NUM:   if (step_r == 4'd2) state_nxt = ST_CHK;
      ST_CHK:   state_nxt = keep_c ? ST_DIV : ST_NXT;
      ST_DIV:   if (dcnt_r == DivCntW'(DvdW - 1)) state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_NXT;
      ST_NXT: begin
        if (!last_edge)         state_nxt = ST_DEN;
        else if (cnt_r == '0)   state_nxt = ST_OWAIT;
        else if (cnt_r == 4'd1) state_nxt = ST_OSCAN;
        else                    state_nxt = ST_RI;
      end
      ST_RI:    state_nxt = ST_RJ;
      ST_RJ: begin
        if (j_r == cnt_r)
          state_nxt = (i_r + 1'b1 == cnt_r) ? ST_OSCAN : ST_RI;
        else if (j_r != i_r)
          state_nxt = ST_RMUL;
      end
      ST_RMUL:  if (step_r == 4'd8) state_nxt = ST_RCMP;
      ST_RCMP:  state_nxt = ST_RJ;
      ST_OSCAN: if (rank_hit) state_nxt = ST_OWAIT;
      ST_OWAIT: if (out_tready) state_nxt = (k_r == cnt_r) ? ST_IDLE : ST_OSCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      k_r         <= '0;
      lo_r[0]     <= BoxMinReset;
      lo_r[1]     <= BoxMinReset;
      lo_r[2]     <= BoxMinReset;
      hi_r[0]     <= BoxMaxReset;
      hi_r[1]     <= BoxMaxReset;
      hi_r[2]     <= BoxMaxReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegMinX: lo_r[0] <= cfg_data;
          RegMinY: lo_r[1] <= cfg_data;
          RegMinZ: lo_r[2] <= cfg_data;
          RegMaxX: hi_r[0] <= cfg_data;
          RegMaxY: hi_r[1] <= cfg_data;
          RegMaxZ: hi_r[2] <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            p_r[0]    <= in_tdata[15:0];
            p_r[1]    <= in_tdata[31:16];
            p_r[2]    <= in_tdata[47:32];
            n_r[0]    <= in_tdata[63:48];
            n_r[1]    <= in_tdata[79:64];
            n_r[2]    <= in_tdata[95:80];
            e_r       <= '0;
            cnt_r     <= '0;
            k_r       <= '0;
            rank_r[0] <= '0;
          end
        end
        ST_DEN: begin
          den_r  <= mul_p[DenW-1:0];
          step_r <= '0;
        end
        ST_NUM: begin
          acc_r  <= (step_r == '0) ? AccW'(mul_p) : acc_r + AccW'(mul_p);
          step_r <= step_r + 1'b1;
        end
        ST_CHK: begin
          qd_r   <= DvdW'({num_abs, 1'b0}) + DvdW'(na_abs);
          dvs_r  <= {na_abs, 1'b0};
          rem_r  <= '0;
          dcnt_r <= '0;
          neg_r  <= num_c[NumW-1] ^ na_c[15];
        end
        ST_DIV: begin
          rem_r  <= dbit ? DvsW'(dsh - {1'b0, dvs_r}) : dsh[DvsW-1:0];
          qd_r   <= {qd_r[DvdW-2:0], dbit};
          dcnt_r <= dcnt_r + 1'b1;
        end
        ST_FIX: begin
          hit_mem[cnt_r].x    <= (ed.axis == 2'd0) ? coord_c : s_c[0];
          hit_mem[cnt_r].y    <= (ed.axis == 2'd1) ? coord_c : s_c[1];
          hit_mem[cnt_r].z    <= (ed.axis == 2'd2) ? coord_c : s_c[2];
          hit_mem[cnt_r].mask <= ed.mask;
          if (cnt_r == '0) begin
            o_r[0] <= 17'((ed.axis == 2'd0) ? coord_c : s_c[0]);
            o_r[1] <= 17'((ed.axis == 2'd1) ? coord_c : s_c[1]);
            o_r[2] <= 17'((ed.axis == 2'd2) ? coord_c : s_c[2]);
          end
          cnt_r <= cnt_r + 1'b1;
        end
        ST_NXT: begin
          e_r  <= e_r + 1'b1;
          i_r  <= 4'd1;
          si_r <= '0;
          r_r  <= '0;
          if (last_edge && cnt_r == '0) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_z_r     <= '0;
            out_idx_r   <= '0;
            out_mask_r  <= '0;
            out_found_r <= 1'b0;
            out_last_r  <= 1'b1;
          end
        end
        ST_RI: begin
          v_r[0] <= 17'(rd_hit.x) - o_r[0];
          v_r[1] <= 17'(rd_hit.y) - o_r[1];
          v_r[2] <= 17'(rd_hit.z) - o_r[2];
          rk_r   <= 4'd1;
          j_r    <= 4'd1;
        end
        ST_RJ: begin
          if (j_r == cnt_r) begin
            rank_r[i_r] <= rk_r;
            i_r         <= i_r + 1'b1;
          end else if (j_r == i_r) begin
            j_r <= j_r + 1'b1;
          end else begin
            u_r[0] <= 17'(rd_hit.x) - o_r[0];
            u_r[1] <= 17'(rd_hit.y) - o_r[1];
            u_r[2] <= 17'(rd_hit.z) - o_r[2];
            step_r <= '0;
          end
        end
        ST_RMUL: begin
          case (step_r)
            4'd0, 4'd3, 4'd6: x_r <= MulAW'(mul_p);
            4'd1, 4'd4, 4'd7: x_r <= x_r - MulAW'(mul_p);
            4'd2:             acc_r <= AccW'(mul_p);
            default:          acc_r <= acc_r + AccW'(mul_p);
          endcase
          step_r <= step_r + 1'b1;
        end
        ST_RCMP: begin
          if (acc_r > 0 || (acc_r == 0 && j_r < i_r))
            rk_r <= rk_r + 1'b1;
          j_r <= j_r + 1'b1;
        end
        ST_OSCAN: begin
          if (scan_wrap) begin
            si_r <= '0;
            r_r  <= r_r + 1'b1;
          end else begin
            si_r <= si_r + 1'b1;
          end
          if (rank_hit) begin
            out_valid_r <= 1'b1;
            out_x_r     <= rd_hit.x;
            out_y_r     <= rd_hit.y;
            out_z_r     <= rd_hit.z;
            out_idx_r   <= si_r;
            out_mask_r  <= rd_hit.mask;
            out_found_r <= 1'b1;
            out_last_r  <= (k_r + 1'b1) == cnt_r;
            k_r         <= k_r + 1'b1;
          end
        end
        ST_OWAIT: begin
          if (out_tready) out_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_mask_r, out_idx_r, out_z_r, out_y_r, out_x_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !out_valid_r) else $error("result pending while idle");
  a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OWAIT) else $error("result valid outside wait");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(NumEdges) && k_r <= cnt_r) else $error("hit count out of range");
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_last_r) else $error("not found without last");
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready right after accept");

endmodule

### test/tb_plane_box_section_polygon.sv
`timescale 1ns / 1ps

module tb_plane_box_section_polygon;
  import pbsp_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [3:0]         idx;
    logic [5:0]         mask;
    logic               found;
    logic               last;
  } section_pt_t;

  class section_scoreboard;
    section_pt_t pending[$];
    longint box_lo[3];
    longint box_hi[3];
    int errors;

    function void reset_box();
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = BoxMinReset;
        box_hi[i] = BoxMaxReset;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic signed [15:0] v);
      if (idx == RegMinX) box_lo[0] = v;
      else if (idx == RegMinY) box_lo[1] = v;
      else if (idx == RegMinZ) box_lo[2] = v;
      else if (idx == RegMaxX) box_hi[0] = v;
      else if (idx == RegMaxY) box_hi[1] = v;
      else if (idx == RegMaxZ) box_hi[2] = v;
    endfunction

    function longint round_div(longint a, longint b);
      longint ua, ub, q;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      q = (2 * ua + ub) / (2 * ub);
      return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_plane(logic [95:0] d);
      longint p[3], n[3], s[3], hp[12][3];
      int hm[12], rk[12];
      int cnt, k;
      longint num, den, c, u0, u1, u2, v0, v1, v2;
      edge_t ed;
      section_pt_t r;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = $signed(d[16*i +: 16]);
        n[i] = $signed(d[48 + 16*i +: 16]);
      end
      for (int e = 0; e < NumEdges; e++) begin
        ed = edge_info(e[3:0]);
        s[0] = ed.cx ? box_hi[0] : box_lo[0];
        s[1] = ed.cy ? box_hi[1] : box_lo[1];
        s[2] = ed.cz ? box_hi[2] : box_lo[2];
        den = n[ed.axis] * (box_hi[ed.axis] - box_lo[ed.axis]);
        if (den == 0) continue;
        num = n[0] * (p[0] - s[0]) + n[1] * (p[1] - s[1]) + n[2] * (p[2] - s[2]);
        if (den > 0 ? (num < 0 || num > den) : (num > 0 || num < den)) continue;
        s[ed.axis] = s[ed.axis] + round_div(num, n[ed.axis]);
        for (int i = 0; i < 3; i++) hp[cnt][i] = clamp16(s[i]);
        hm[cnt] = ed.mask;
        cnt++;
      end
      if (cnt == 0) begin
        r = '{0, 0, 0, 0, 0, 1'b0, 1'b1};
        pending.insert(pending.size(), r);
        return;
      end
      rk[0] = 0;
      for (int i = 1; i < cnt; i++) begin
        rk[i] = 1;
        for (int j = 1; j < cnt; j++) begin
          if (j == i) continue;
          u0 = hp[j][0] - hp[0][0]; u1 = hp[j][1] - hp[0][1]; u2 = hp[j][2] - hp[0][2];
          v0 = hp[i][0] - hp[0][0]; v1 = hp[i][1] - hp[0][1]; v2 = hp[i][2] - hp[0][2];
          c = (u1 * v2 - u2 * v1) * n[0] + (u2 * v0 - u0 * v2) * n[1]
            + (u0 * v1 - u1 * v0) * n[2];
          if (c > 0 || (c == 0 && j < i)) rk[i]++;
        end
      end
      k = 0;
      for (int q = 0; q < cnt; q++)
        for (int i = 0; i < cnt; i++)
          if (rk[i] == q) begin
            r.x = hp[i][0]; r.y = hp[i][1]; r.z = hp[i][2];
            r.idx = i; r.mask = hm[i]; r.found = 1'b1;
            r.last = (k + 1 == cnt);
            pending.insert(pending.size(), r);
            k++;
          end
    endfunction

    function void check_point(logic [63:0] d, logic user, logic lst);
      section_pt_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer tdata=%h", d);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.x || d[31:16] !== e.y || d[47:32] !== e.z || d[51:48] !== e.idx
          || d[57:52] !== e.mask || d[63:58] !== 6'd0 || user !== e.found
          || lst !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %0d %0d %0d idx%0d m%h f%b l%b got tdata=%h u%b l%b",
                   e.x, e.y, e.z, e.idx, e.mask, e.found, e.last, d, user, lst);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser, out_tlast;
  logic [95:0] in_tdata;
  logic [63:0] out_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  section_scoreboard sb;
  int hold_off;
  longint cycles;

  plane_box_section_polygon uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    in_tvalid = 0; in_tdata = '0; out_tready = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    rst_n = 0; hold_off = 0;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_plane(in_tdata);
    if (out_tvalid && out_tready) sb.check_point(out_tdata, out_tuser, out_tlast);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 3);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_plane(logic [95:0] d);
    int w;
    w = $urandom_range(0, 3);
    cfg_we <= 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk iff in_tready);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk iff sb.pending.size() == 0);
    repeat (2500) @(posedge clk);
  endtask

  function automatic logic [95:0] mk(int px, int py, int pz, int nx, int ny, int nz);
    logic [15:0] a[6];
    a = '{px[15:0], py[15:0], pz[15:0], nx[15:0], ny[15:0], nz[15:0]};
    return {a[5], a[4], a[3], a[2], a[1], a[0]};
  endfunction

  function automatic int rnorm();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 1) ? 16384 : -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic int rcoord(int lim);
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic random_planes(int count, int lim);
    for (int i = 0; i < count; i++)
      send_plane(mk(rcoord(lim), rcoord(lim), rcoord(lim), rnorm(), rnorm(), rnorm()));
  endtask

  initial begin
    sb = new();
    sb.reset_box();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed, reset box
    send_plane(mk(0, 0, 0, 0, 0, 16384));
    send_plane(mk(0, 0, 0, 16384, 0, 0));
    send_plane(mk(0, 0, 0, 0, -16384, 0));
    send_plane(mk(0, 0, 0, 9459, 9459, 9459));
    send_plane(mk(0, 0, 0, -9459, 9459, -9459));
    send_plane(mk(0, 0, 0, 0, 0, 0));
    send_plane(mk(2048, 2048, 2048, 9459, 9459, 9459));
    send_plane(mk(-2048, -2048, 0, 16384, 0, 0));
    send_plane(mk(0, 0, 4096, 0, 0, 16384));
    send_plane(mk(32767, -32768, 32767, -16384, 16384, -16384));
    send_plane(mk(-32768, 32767, -32768, 16384, -16384, 16384));
    send_plane(mk(0, 0, 2048, 11585, 0, 11585));
    send_plane(mk(100, -300, 50, 3, -7, 16383));
    drain();
    // large box, saturating hits
    write_cfg(RegMinX, 16'h8000); write_cfg(RegMinY, 16'h8000);
    write_cfg(RegMinZ, 16'h8000); write_cfg(RegMaxX, 16'h7FFF);
    write_cfg(RegMaxY, 16'h7FFF); write_cfg(RegMaxZ, 16'h7FFF);
    write_cfg(3'd6, 16'h1234);
    send_plane(mk(0, 0, 0, 1, 1, 16384));
    send_plane(mk(32767, 32767, 32767, -16384, 1, 3));
    send_plane(mk(0, 0, 0, 9459, -9459, 9459));
    random_planes(20, 32767);
    drain();
    // pressure: long receiver hold-off while planes keep coming
    hold_off = 3000;
    random_planes(5, 32767);
    drain();
    // inverted box, flat box
    write_cfg(RegMinX, 16'sd3000); write_cfg(RegMaxX, -16'sd1000);
    write_cfg(RegMinY, -16'sd500); write_cfg(RegMaxY, 16'sd4000);
    write_cfg(RegMinZ, 16'sd0); write_cfg(RegMaxZ, 16'sd0);
    random_planes(35, 5000);
    drain();
    write_cfg(RegMinZ, -16'sd2500); write_cfg(RegMaxZ, 16'sd1500);
    random_planes(35, 5000);
    drain();
    sb.reset_box();
    for (int i = 0; i < 6; i++) write_cfg(i[2:0], i < 3 ? BoxMinReset : BoxMaxReset);
    random_planes(40, 3000);
    drain();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
